/* design/sbpc_pkg.sv */
// Shared types and constants for the swept box pair collision block.
// Used by the front, queue and back modules and the top level.
// No dependencies.
package sbpc_pkg;

	localparam int MAX_ACTORS_DEF = 32;
	localparam int RESULT_CAP     = 32;
	localparam int INDEX_W        = $clog2(RESULT_CAP);
	localparam int QUEUE_DEPTH    = 2;
	localparam int FRAC_BITS      = 8;

	localparam logic [1:0] USABLE_ALL = 2'b11;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_RUN  = 1'b1
	} cmd_code_t;

	// Stored form of one actor: swept box, masks and usable flags
	// (bit 0 active, bit 1 both sizes nonzero).
	typedef struct packed {
		logic signed [32:0] x_low;
		logic signed [32:0] x_high;
		logic signed [32:0] y_low;
		logic signed [32:0] y_high;
		logic [15:0]        layer;
		logic [15:0]        accept;
		logic [1:0]         usable;
	} actor_t;

	typedef struct packed {
		cmd_code_t code;
		actor_t    actor;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

	typedef struct packed {
		logic busy;
		logic has_actors;
	} back_stat_t;

endpackage

/* design/sbpc_item_if.sv */
// Input channel of the swept box pair collision block: valid/ready plus one item.
// Depends on nothing.
interface sbpc_item_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] prev_x;
	logic signed [31:0] prev_y;
	logic [11:0]        box_width;
	logic [11:0]        box_height;
	logic [15:0]        layer_bits;
	logic [15:0]        accept_bits;
	logic               is_active;

	modport source (
		output valid, command, pos_x, pos_y, prev_x, prev_y,
		       box_width, box_height, layer_bits, accept_bits, is_active,
		input  ready
	);
	modport sink (
		input  valid, command, pos_x, pos_y, prev_x, prev_y,
		       box_width, box_height, layer_bits, accept_bits, is_active,
		output ready
	);
endinterface

/* design/sbpc_result_if.sv */
// Result channel of the swept box pair collision block: valid/ready plus one result.
// Depends on nothing.
interface sbpc_result_if;
	logic        valid;
	logic        ready;
	logic [4:0]  actor_index;
	logic [31:0] partner_bits;
	logic        last_of_run;
	logic        store_empty;

	modport source (
		output valid, actor_index, partner_bits, last_of_run, store_empty,
		input  ready
	);
	modport sink (
		input  valid, actor_index, partner_bits, last_of_run, store_empty,
		output ready
	);
endinterface

/* design/swept_box_pair_collision.sv */
// Swept box pair collision, top level: front stage, two-entry queue, back end.
// A load passes the front register and a queue slot into the store; a run takes the
// same path and gives its results through the result register. Throughput: one load
// per cycle while no run is in progress; a run of n actors has a setup step, then gives
// min(n, 32) results at one per cycle while results are taken, one left actor each.
// Reset: asynchronous, clears control and the actor count; store contents stay undefined.
module swept_box_pair_collision #(
	parameter int MAX_ACTORS = sbpc_pkg::MAX_ACTORS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	sbpc_item_if.sink     item,
	sbpc_result_if.source result
);

	logic                 push_valid, push_ready;
	sbpc_pkg::cmd_t       push_data;
	logic                 pop_valid, pop_ready;
	sbpc_pkg::cmd_t       pop_data;
	sbpc_pkg::back_stat_t stat;

	sbpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	sbpc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	sbpc_back #(
		.MAX_ACTORS (MAX_ACTORS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_data  (pop_data),
		.cmd_ready (pop_ready),
		.result    (result),
		.stat      (stat)
	);

	// an empty-store result is the whole run and reports no partners
	a_empty_single: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.store_empty |-> result.last_of_run && result.partner_bits == '0)
		else $error("empty-store result malformed");

	// partners are only ever of higher index
	a_higher_only: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |->
		(result.partner_bits & ((33'd2 << result.actor_index) - 33'd1)) == '0)
		else $error("partner bit at or below actor index");

	// the store is cleared only once the run has finished
	a_run_has_actors: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> stat.has_actors)
		else $error("run in progress with empty store");

	// a run result is never flagged as an empty store
	a_run_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy && result.valid && result.ready |=> !result.store_empty || !result.valid)
		else $error("run result marked empty");

endmodule

/* design/sbpc_front.sv */
// Front end: takes input transfers, classifies them and builds the swept box.
// Depends on sbpc_pkg and sbpc_item_if.
module sbpc_front (
	input  logic            clk,
	input  logic            arst_n,
	sbpc_item_if.sink       item,
	output logic            push_valid,
	output sbpc_pkg::cmd_t  push_data,
	input  logic            push_ready
);

	logic               valid_s1;
	sbpc_pkg::cmd_t     cmd_s1;
	sbpc_pkg::cmd_t     cmd_d;
	logic signed [32:0] px, py, qx, qy;
	logic signed [32:0] w_fix, h_fix;
	logic signed [32:0] x_max, y_max;
	logic               take;

	assign item.ready = !valid_s1 || push_ready;
	assign take       = item.valid && item.ready;

	always_comb begin
		px    = 33'(item.pos_x);
		py    = 33'(item.pos_y);
		qx    = 33'(item.prev_x);
		qy    = 33'(item.prev_y);
		w_fix = $signed({13'd0, item.box_width, 8'd0});
		h_fix = $signed({13'd0, item.box_height, 8'd0});
		x_max = (px > qx) ? px : qx;
		y_max = (py > qy) ? py : qy;

		cmd_d.code          = sbpc_pkg::cmd_code_t'(item.command);
		cmd_d.actor.x_low   = (px < qx) ? px : qx;
		cmd_d.actor.y_low   = (py < qy) ? py : qy;
		// max(p + w, q + w) == max(p, q) + w
		cmd_d.actor.x_high  = x_max + w_fix;
		cmd_d.actor.y_high  = y_max + h_fix;
		cmd_d.actor.layer   = item.layer_bits;
		cmd_d.actor.accept  = item.accept_bits;
		cmd_d.actor.usable  = {(item.box_width != 12'd0) && (item.box_height != 12'd0),
		                       item.is_active};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_data  = cmd_s1;

endmodule

/* design/sbpc_queue.sv */
// Short command queue between front and back.
// Depends on sbpc_pkg.
module sbpc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  sbpc_pkg::cmd_t  push_data,
	output logic            push_ready,
	output logic            pop_valid,
	output sbpc_pkg::cmd_t  pop_data,
	input  logic            pop_ready
);

	localparam int DEPTH = sbpc_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	sbpc_pkg::cmd_t slot_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  fill_q;
	logic           do_push, do_pop;

	assign push_ready = (fill_q != CW'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* design/sbpc_back.sv */
// Back end: actor store, pair test lanes, run sequencer and result register.
// Depends on sbpc_pkg and sbpc_result_if.
module sbpc_back #(
	parameter int MAX_ACTORS = sbpc_pkg::MAX_ACTORS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  sbpc_pkg::cmd_t       cmd_data,
	output logic                 cmd_ready,
	sbpc_result_if.source        result,
	output sbpc_pkg::back_stat_t stat
);

	localparam int CW  = $clog2(MAX_ACTORS + 1);
	localparam int IW  = $clog2(MAX_ACTORS);
	localparam int XW  = sbpc_pkg::INDEX_W;
	localparam int SHW = MAX_ACTORS + sbpc_pkg::RESULT_CAP;

	sbpc_pkg::back_state_t state_q, state_d;
	sbpc_pkg::actor_t      store_q [MAX_ACTORS];
	logic [CW-1:0]         count_q, rem_q;
	logic [XW-1:0]         idx_q;

	logic                  rvalid_q;
	logic [4:0]            rindex_q;
	logic [31:0]           rbits_q;
	logic                  rlast_q, rempty_q;

	logic                  out_free;
	logic                  do_load, start_run, emit_empty, step, last;
	logic [MAX_ACTORS-1:0] hit;
	logic [SHW-1:0]        hit_shifted;
	sbpc_pkg::actor_t      head;

	assign out_free = !rvalid_q || result.ready;
	assign head     = store_q[0];
	assign last     = (rem_q == CW'(1)) || (idx_q == XW'(sbpc_pkg::RESULT_CAP - 1));

	// Lane p tests the head (left actor) against the entry p places behind it.
	always_comb begin
		hit = '0;
		for (int p = 1; p < MAX_ACTORS; p++) begin
			hit[p] = (CW'(p) < rem_q)
			      && (head.usable == sbpc_pkg::USABLE_ALL)
			      && (store_q[p].usable == sbpc_pkg::USABLE_ALL)
			      && ((head.accept & store_q[p].layer) != 16'd0)
			      && ((store_q[p].accept & head.layer) != 16'd0)
			      && (store_q[p].x_low < head.x_high)
			      && (store_q[p].x_high > head.x_low)
			      && (store_q[p].y_low < head.y_high)
			      && (store_q[p].y_high > head.y_low);
		end
		hit_shifted = SHW'(hit) << idx_q;
	end

	always_comb begin
		state_d    = state_q;
		cmd_ready  = 1'b0;
		do_load    = 1'b0;
		start_run  = 1'b0;
		emit_empty = 1'b0;
		step       = 1'b0;
		unique case (state_q)
			sbpc_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					if (cmd_data.code == sbpc_pkg::CMD_LOAD) begin
						cmd_ready = 1'b1;
						do_load   = 1'b1;
					end else if (count_q == '0) begin
						cmd_ready  = out_free;
						emit_empty = out_free;
					end else begin
						cmd_ready = 1'b1;
						start_run = 1'b1;
						state_d   = sbpc_pkg::BK_RUN;
					end
				end
			end
			sbpc_pkg::BK_RUN: begin
				step = out_free;
				if (out_free && last) begin
					state_d = sbpc_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = sbpc_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sbpc_pkg::BK_IDLE;
			count_q  <= '0;
			rem_q    <= '0;
			idx_q    <= '0;
			rvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// a load into a full store is dropped
			if (do_load && (count_q != CW'(MAX_ACTORS))) begin
				count_q <= count_q + CW'(1);
			end
			if (start_run) begin
				rem_q <= count_q;
				idx_q <= '0;
			end else if (step) begin
				rem_q <= rem_q - CW'(1);
				idx_q <= idx_q + XW'(1);
				if (last) begin
					count_q <= '0;
				end
			end
			if (emit_empty || step) begin
				rvalid_q <= 1'b1;
			end else if (result.ready) begin
				rvalid_q <= 1'b0;
			end
		end
	end

	// Store: written at the fill count on load, shifted towards the head during a run.
	always_ff @(posedge clk) begin
		if (do_load && (count_q != CW'(MAX_ACTORS))) begin
			store_q[count_q[IW-1:0]] <= cmd_data.actor;
		end else if (step) begin
			for (int p = 0; p < MAX_ACTORS - 1; p++) begin
				store_q[p] <= store_q[p + 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_empty) begin
			rindex_q <= '0;
			rbits_q  <= '0;
			rlast_q  <= 1'b1;
			rempty_q <= 1'b1;
		end else if (step) begin
			rindex_q <= 5'(idx_q);
			rbits_q  <= hit_shifted[31:0];
			rlast_q  <= last;
			rempty_q <= 1'b0;
		end
	end

	assign result.valid        = rvalid_q;
	assign result.actor_index  = rindex_q;
	assign result.partner_bits = rbits_q;
	assign result.last_of_run  = rlast_q;
	assign result.store_empty  = rempty_q;

	assign stat.busy       = (state_q == sbpc_pkg::BK_RUN);
	assign stat.has_actors = (count_q != '0);

endmodule

/* tb/swept_box_pair_collision_tb.sv */
// Testbench for swept_box_pair_collision: directed and random loads and runs, with results
// checked against a scoreboard that predicts the partner masks of every run.
// Depends on sbpc_pkg, sbpc_item_if, sbpc_result_if and the block itself.
`timescale 1ns / 100ps

module swept_box_pair_collision_tb;

	localparam int MAX_ACTORS   = sbpc_pkg::MAX_ACTORS_DEF;
	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 11;
	localparam int ITEM_TARGET  = 205;
	localparam int PAUSE_AT     = 100;
	localparam int QUIET_AT     = 180;
	localparam int DRAIN_CYCLES = 50;
	localparam int TIMEOUT_NS   = 2_000_000;

	typedef struct packed {
		sbpc_pkg::cmd_code_t command;
		logic signed [31:0]  pos_x;
		logic signed [31:0]  pos_y;
		logic signed [31:0]  prev_x;
		logic signed [31:0]  prev_y;
		logic [11:0]         box_width;
		logic [11:0]         box_height;
		logic [15:0]         layer_bits;
		logic [15:0]         accept_bits;
		logic                is_active;
	} actor_cmd_t;

	typedef struct packed {
		logic [4:0]  actor_index;
		logic [31:0] partner_bits;
		logic        last_of_run;
		logic        store_empty;
	} partner_row_t;

	class collision_scoreboard;
		sbpc_pkg::actor_t store[MAX_ACTORS];
		int unsigned      stored;
		partner_row_t     awaited[$];
		int unsigned      errors;

		function new();
			stored = 0;
			errors = 0;
		endfunction

		function int unsigned outstanding();
			return awaited.size();
		endfunction

		// Swept box over both positions; sizes are whole units, hence the shift by 8.
		function sbpc_pkg::actor_t sweep_of(actor_cmd_t it);
			sbpc_pkg::actor_t   a;
			logic signed [32:0] px, py, qx, qy, w, h;
			px = 33'($signed(it.pos_x));
			py = 33'($signed(it.pos_y));
			qx = 33'($signed(it.prev_x));
			qy = 33'($signed(it.prev_y));
			w = {13'd0, it.box_width, 8'd0};
			h = {13'd0, it.box_height, 8'd0};
			a.x_low = (px < qx) ? px : qx;
			a.y_low = (py < qy) ? py : qy;
			a.x_high = (px + w > qx + w) ? px + w : qx + w;
			a.y_high = (py + h > qy + h) ? py + h : qy + h;
			a.layer = it.layer_bits;
			a.accept = it.accept_bits;
			a.usable = {(w != 0 && h != 0), it.is_active};
			return a;
		endfunction

		function bit boxes_hit(sbpc_pkg::actor_t a, sbpc_pkg::actor_t b);
			if (a.usable != sbpc_pkg::USABLE_ALL || b.usable != sbpc_pkg::USABLE_ALL)
				return 0;
			if ((a.accept & b.layer) == 0 || (b.accept & a.layer) == 0)
				return 0;
			if ($signed(b.x_low) >= $signed(a.x_high) || $signed(b.x_high) <= $signed(a.x_low))
				return 0;
			if ($signed(b.y_low) >= $signed(a.y_high) || $signed(b.y_high) <= $signed(a.y_low))
				return 0;
			return 1;
		endfunction

		function void note_item(actor_cmd_t it);
			int unsigned  emit;
			partner_row_t row;
			if (it.command == sbpc_pkg::CMD_LOAD) begin
				// full store: load dropped
				if (stored < MAX_ACTORS) begin
					store[stored] = sweep_of(it);
					stored++;
				end
			end else if (stored == 0) begin
				awaited.push_back('{5'd0, 32'd0, 1'b1, 1'b1});
			end else begin
				emit = (stored < sbpc_pkg::RESULT_CAP) ? stored : sbpc_pkg::RESULT_CAP;
				for (int i = 0; i < emit; i++) begin
					row = '0;
					row.actor_index = i[4:0];
					for (int j = i + 1; j < emit; j++)
						if (boxes_hit(store[i], store[j]))
							row.partner_bits[j] = 1'b1;
					row.last_of_run = (i + 1 == emit);
					awaited.push_back(row);
				end
				stored = 0;
			end
		endfunction

		function void check_result(partner_row_t got);
			partner_row_t want;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result %0d/%h/%b/%b", $realtime,
						got.actor_index, got.partner_bits, got.last_of_run, got.store_empty);
				return;
			end
			want = awaited.pop_front();
			if (got.actor_index !== want.actor_index || got.partner_bits !== want.partner_bits ||
			    got.last_of_run !== want.last_of_run || got.store_empty !== want.store_empty) begin
				errors++;
				// fields: index/bits/last/empty
				if (errors <= 10)
					$display("%0t: expected %0d/%h/%b/%b, got %0d/%h/%b/%b",
						$realtime, want.actor_index, want.partner_bits, want.last_of_run,
						want.store_empty, got.actor_index, got.partner_bits, got.last_of_run,
						got.store_empty);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   quiet;
	int   stall_left;
	int   sent;

	collision_scoreboard sb = new();

	sbpc_item_if   item_ch ();
	sbpc_result_if result_ch ();

	swept_box_pair_collision #(.MAX_ACTORS(MAX_ACTORS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		#(TIMEOUT_NS);
		$display("** swept_box_pair_collision: FAILED **");
		$finish;
	end

	// Result side: check every transfer, stall in random bursts until the quiet phase.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_ch.valid && result_ch.ready)
				sb.check_result('{result_ch.actor_index, result_ch.partner_bits,
					result_ch.last_of_run, result_ch.store_empty});
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 5) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input actor_cmd_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.command     <= it.command;
		item_ch.pos_x       <= it.pos_x;
		item_ch.pos_y       <= it.pos_y;
		item_ch.prev_x      <= it.prev_x;
		item_ch.prev_y      <= it.prev_y;
		item_ch.box_width   <= it.box_width;
		item_ch.box_height  <= it.box_height;
		item_ch.layer_bits  <= it.layer_bits;
		item_ch.accept_bits <= it.accept_bits;
		item_ch.is_active   <= it.is_active;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		sb.note_item(it);
		sent++;
	endtask

	function automatic actor_cmd_t load_at(int x, int y, int px, int py, int w, int h,
			int layer, int accept, bit active);
		actor_cmd_t it;
		it.command = sbpc_pkg::CMD_LOAD;
		it.pos_x = x;
		it.pos_y = y;
		it.prev_x = px;
		it.prev_y = py;
		it.box_width = w[11:0];
		it.box_height = h[11:0];
		it.layer_bits = layer[15:0];
		it.accept_bits = accept[15:0];
		it.is_active = active;
		return it;
	endfunction

	function automatic int near_origin();
		return int'($urandom_range(0, 6144)) - 3072;
	endfunction

	function automatic int drift();
		if ($urandom_range(0, 4) == 0)
			return int'($urandom_range(0, 4096)) - 2048;
		return int'($urandom_range(0, 512)) - 256;
	endfunction

	// Mostly clustered boxes so pairs really meet; some full-range, some that can never hit.
	function automatic actor_cmd_t rand_load();
		actor_cmd_t  it;
		int unsigned kind;
		kind = $urandom_range(0, 99);
		it.command = sbpc_pkg::CMD_LOAD;
		if (kind < 15) begin
			it.pos_x = $urandom();
			it.pos_y = $urandom();
			it.prev_x = $urandom();
			it.prev_y = $urandom();
			it.box_width = 12'($urandom_range(0, 4095));
			it.box_height = 12'($urandom_range(0, 4095));
			it.layer_bits = 16'($urandom());
			it.accept_bits = 16'($urandom());
			it.is_active = 1'($urandom_range(0, 1));
		end else begin
			it.pos_x = near_origin();
			it.pos_y = near_origin();
			it.prev_x = it.pos_x + drift();
			it.prev_y = it.pos_y + drift();
			it.box_width = 12'($urandom_range(1, 12));
			it.box_height = 12'($urandom_range(1, 12));
			it.layer_bits = ($urandom_range(0, 4) == 0) ? 16'($urandom())
				: 16'($urandom_range(1, 15));
			it.accept_bits = ($urandom_range(0, 4) == 0) ? 16'($urandom())
				: 16'($urandom_range(1, 15));
			it.is_active = ($urandom_range(0, 9) != 0);
			if (kind < 30) begin
				case ($urandom_range(0, 5))
					0: it.box_width = '0;
					1: it.box_height = '0;
					2: it.is_active = 1'b0;
					3: it.layer_bits = '0;
					4: it.accept_bits = '0;
					default: it.box_width = 12'hFFF;
				endcase
			end
		end
		return it;
	endfunction

	function automatic actor_cmd_t rand_run();
		actor_cmd_t it;
		it = rand_load();
		it.command = sbpc_pkg::CMD_RUN;
		return it;
	endfunction

	initial begin
		actor_cmd_t  run_item;
		int unsigned group_size;
		bit          paused;
		bit          first_group;

		arst_n = 1'b0;
		quiet = 1'b0;
		sent = 0;
		paused = 1'b0;
		first_group = 1'b1;
		item_ch.valid       <= 1'b0;
		item_ch.command     <= sbpc_pkg::CMD_LOAD;
		item_ch.pos_x       <= '0;
		item_ch.pos_y       <= '0;
		item_ch.prev_x      <= '0;
		item_ch.prev_y      <= '0;
		item_ch.box_width   <= '0;
		item_ch.box_height  <= '0;
		item_ch.layer_bits  <= '0;
		item_ch.accept_bits <= '0;
		item_ch.is_active   <= 1'b0;
		run_item = '0;
		run_item.command = sbpc_pkg::CMD_RUN;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// run on an empty store
		send_item(run_item);
		send_item(load_at(0, 0, 0, 0, 2, 2, 1, 1, 1));
		send_item(load_at(256, 256, 256, 256, 2, 2, 1, 1, 1));
		// left edge exactly on the first box's right edge: strict test, no hit
		send_item(load_at(512, 0, 512, 0, 2, 2, 1, 1, 1));
		send_item(load_at(0, 0, 0, 0, 2, 2, 1, 1, 0));
		send_item(load_at(0, 0, 0, 0, 0, 2, 1, 1, 1));
		send_item(load_at(0, 0, 0, 0, 2, 0, 1, 1, 1));
		send_item(load_at(0, 0, 0, 0, 2, 2, 2, 1, 1));
		// accepted by the others but does not accept them back
		send_item(load_at(0, 0, 0, 0, 2, 2, 1, 2, 1));
		// far position, swept back over the origin
		send_item(load_at(25600, 0, 0, 0, 1, 1, 1, 1, 1));
		send_item(load_at(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
			4095, 4095, 'hFFFF, 'hFFFF, 1));
		send_item(load_at(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			4095, 4095, 'hFFFF, 'hFFFF, 1));
		send_item(load_at(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			4095, 4095, 'h8000, 'h8000, 1));
		send_item(run_item);
		// store was emptied by the run
		send_item(run_item);
		send_item(load_at(-256, -256, 0, 0, 1, 1, 1, 1, 1));
		send_item(run_item);

		while (sent < ITEM_TARGET) begin
			// first group overfills the store
			if (first_group)
				group_size = MAX_ACTORS + 2;
			else if ($urandom_range(0, 6) == 0)
				group_size = $urandom_range(20, MAX_ACTORS + 2);
			else
				group_size = $urandom_range(0, 8);
			first_group = 1'b0;
			repeat (group_size)
				send_item(rand_load());
			send_item(rand_run());
			if (!paused && sent >= PAUSE_AT) begin
				item_ch.valid <= 1'b0;
				while (sb.outstanding() != 0)
					@(posedge clk);
				paused = 1'b1;
			end
			if (sent >= QUIET_AT)
				quiet = 1'b1;
		end

		item_ch.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("** swept_box_pair_collision: PASSED **");
		else
			$display("** swept_box_pair_collision: FAILED **");
		$finish;
	end

endmodule
